FILE: src/sts_pkg.sv
// Shared types and constants for the sorted table binary search unit.
// No dependencies.
package sts_pkg;

    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // item kinds carried on tuser
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef logic signed [VALUE_W-1:0] value_t;

endpackage

FILE: src/sts_table.sv
// Entry table storage: one write port, one registered read port.
// Depends on sts_pkg.
module sts_table
    import sts_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  value_t            wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output value_t            rd_data
);

    value_t mem [DEPTH];
    value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/sorted_table_binary_search_unit.sv
// Sorted table binary search unit, top level.
// Depends on sts_pkg and sts_table.
//
// Usage:
//   Input items arrive on s_axis_*: tuser is the kind (0 write, 1 search),
//   tdata holds position and value. A write stores value at position and
//   gives no result; positions at or beyond TABLE_DEPTH are dropped.
//   A search does a binary search for value over the first entry_count
//   entries (capped at TABLE_DEPTH) and returns one item on m_axis_*:
//   tuser is found, tdata the matching position (0 when not found).
//   entry_count is set through the APB port at address 0.
// Timing:
//   One probe of the table RAM per cycle; the registered RAM read sets the
//   pace. A search over n entries takes up to floor(log2 n)+1 probes, so
//   s_axis_tready is low from when a search is taken until its result is
//   loaded into the output register, including any wait for that register.
// Reset:
//   rst_n clears the sequencer, output valid and entry_count; the table
//   contents are undefined until written.
// Stall:
//   A pending result is held until m_axis_tready. New items are still taken
//   meanwhile; a finished search waits in its final state until the output
//   register frees.
module sorted_table_binary_search_unit
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [39:0]         s_axis_tdata,   // [5:0] position, [37:6] value, [39:38] zero
    input  logic                s_axis_tuser,   // [0] opcode

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [5:0] match_position, [7:6] zero
    output logic                m_axis_tuser,   // [0] found

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW     = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [IW-1:0]       lo_reg, lo_next;
    logic [IW-1:0]       hp1_reg, hp1_next;      // high bound + 1
    logic [ADDR_W-1:0]   mid_reg, mid_next;
    value_t              key_reg, key_next;
    logic                hit_reg, hit_next;
    logic [POS_W-1:0]    res_pos_reg, res_pos_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_found_reg, m_found_next;
    logic [POS_W-1:0]    m_pos_reg, m_pos_next;
    logic [COUNT_W-1:0]  entry_count_reg;

    logic [POS_W-1:0]    in_pos;
    value_t              in_value;
    logic                in_take;
    logic                tbl_wr_en;
    logic [ADDR_W-1:0]   rd_addr;
    value_t              rd_data;
    logic [IW-1:0]       eff_count;
    logic [ADDR_W-1:0]   mid_first;
    logic [IW:0]         mid_sum;
    logic                probe_eq;
    logic                probe_gt;
    logic                cfg_wr;

    assign in_pos   = s_axis_tdata[POS_W-1:0];
    assign in_value = value_t'(s_axis_tdata[POS_W+VALUE_W-1:POS_W]);
    assign in_take  = s_axis_tvalid && s_axis_tready;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            entry_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ENTRY_COUNT)
        begin
            prdata = APB_DW'(entry_count_reg);
        end
    end

    assign eff_count = (32'(entry_count_reg) > 32'(TABLE_DEPTH))
                       ? IW'(TABLE_DEPTH) : IW'(entry_count_reg);
    assign mid_first = ADDR_W'((eff_count - IW'(1)) >> 1);

    // table
    assign tbl_wr_en = in_take && (s_axis_tuser == OP_WRITE)
                       && (32'(in_pos) < 32'(TABLE_DEPTH));

    sts_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (ADDR_W'(in_pos)),
        .wr_data (in_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign probe_eq = (rd_data == key_reg);
    assign probe_gt = (rd_data > key_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hp1_next     = hp1_reg;
        mid_next     = mid_reg;
        key_next     = key_reg;
        hit_next     = hit_reg;
        res_pos_next = res_pos_reg;
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_pos_next   = m_pos_reg;
        rd_addr      = mid_first;
        mid_sum      = '0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (s_axis_tuser == OP_SEARCH))
                begin
                    key_next     = in_value;
                    lo_next      = '0;
                    hp1_next     = eff_count;
                    mid_next     = mid_first;
                    hit_next     = 1'b0;
                    res_pos_next = '0;
                    state_next   = (eff_count == '0) ? ST_EMIT : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (probe_eq)
                begin
                    hit_next     = 1'b1;
                    res_pos_next = POS_W'(mid_reg);
                    state_next   = ST_EMIT;
                end
                else
                begin
                    if (probe_gt)
                    begin
                        hp1_next = IW'(mid_reg);
                    end
                    else
                    begin
                        lo_next = IW'(mid_reg) + IW'(1);
                    end
                    mid_sum  = (IW+1)'(lo_next) + (IW+1)'(hp1_next) - (IW+1)'(1);
                    mid_next = ADDR_W'(mid_sum >> 1);
                    rd_addr  = mid_next;
                    if (lo_next >= hp1_next)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_found_next = hit_reg;
                    m_pos_next   = res_pos_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            lo_reg      <= '0;
            hp1_reg     <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lo_reg      <= lo_next;
            hp1_reg     <= hp1_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg     <= mid_next;
        key_reg     <= key_next;
        res_pos_reg <= res_pos_next;
        m_found_reg <= m_found_next;
        m_pos_reg   <= m_pos_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_found_reg;
    assign m_axis_tdata  = {2'b00, m_pos_reg};

`ifndef SYNTHESIS
    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (lo_reg < hp1_reg))
        else $error("probe with empty search window");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (hp1_reg <= eff_count))
        else $error("search window beyond entry count");

    a_empty_search: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (s_axis_tuser == OP_SEARCH) && (eff_count == '0))
        |=> (state_reg == ST_EMIT) && !hit_reg)
        else $error("empty search did not finish at once");

    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("miss result with nonzero position");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && hit_reg) |-> (32'(res_pos_reg) < 32'(eff_count)))
        else $error("hit position outside searched range");
`endif

endmodule
